// File: sv/digit_string_to_decimal96_core_assert.svh
// Assertion macros for the digit string to decimal converter.
// Depends on nothing; included by the modules that carry assertions.
// ASSERT_OFF removes every check.
`ifndef DIGIT_STRING_TO_DECIMAL96_CORE_ASSERT_SVH
`define DIGIT_STRING_TO_DECIMAL96_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/dsd96_pkg.sv
// Package for the digit string to decimal converter: widths, constants,
// phase and microcode types, and the microprogram ROM. Depends on nothing.
`timescale 1ns / 1ps

package dsd96_pkg;

    localparam int unsigned MANT_W   = 96;
    localparam int unsigned LOW_W    = 64;
    localparam int unsigned HIGH_W   = 32;
    localparam int unsigned EXP_W    = 16;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned SCALE_W  = 5;
    localparam int unsigned ZRUN_W   = 5;
    localparam int unsigned STEP_W   = 4;

    localparam logic [ZRUN_W-1:0]        LOOKAHEAD_ZEROS = 5'd20;
    localparam logic [MANT_W-1:0]        MANT_LIMIT      = {32'h19999999, 64'h9999999999999999};
    localparam logic [MANT_W-1:0]        MANT_CARRY_FIX  = {32'h19999999, 64'h999999999999999A};
    localparam logic signed [EXP_W-1:0]  EXP_MAX         = 16'sd29;
    localparam logic signed [EXP_W-1:0]  EXP_MIN_ACC     = -16'sd28;
    localparam logic signed [EXP_W-1:0]  EXP_TINY        = -16'sd29;
    localparam logic [SCALE_W-1:0]       SCALE_TINY      = 5'd28;
    localparam logic [DIGIT_W-1:0]       DIGIT_HALF      = 4'd5;

    typedef enum logic [2:0] {
        PH_ACC,
        PH_LOOK,
        PH_SINK,
        PH_FAIL,
        PH_IDLE
    } t_phase;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_SAW,
        ACT_CLASSIFY,
        ACT_MUL10,
        ACT_ADD_DIGIT,
        ACT_MUL10_EXP,
        ACT_ADD_ONE,
        ACT_CARRY_FIX,
        ACT_EMIT
    } t_act;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_IDLE,
        C_TERM,
        C_CONSUME,
        C_NO_SCALE_UP,
        C_NO_ROUND,
        C_NOT_ALL_ONES,
        C_OUT_BUSY
    } t_cond;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_FETCH     = 4'd0;
    localparam t_step STEP_CHK_IDLE  = 4'd1;
    localparam t_step STEP_CHK_TERM  = 4'd2;
    localparam t_step STEP_SAW       = 4'd3;
    localparam t_step STEP_CHK_CONS  = 4'd4;
    localparam t_step STEP_CLASSIFY  = 4'd5;
    localparam t_step STEP_MUL10     = 4'd6;
    localparam t_step STEP_ADD_DIGIT = 4'd7;
    localparam t_step STEP_SCALE_CHK = 4'd8;
    localparam t_step STEP_SCALE_MUL = 4'd9;
    localparam t_step STEP_ROUND_CHK = 4'd10;
    localparam t_step STEP_ROUND_ADD = 4'd11;
    localparam t_step STEP_CARRY_FIX = 4'd12;
    localparam t_step STEP_OUT_WAIT  = 4'd13;
    localparam t_step STEP_EMIT      = 4'd14;
    localparam t_step STEP_SPARE     = 4'd15;

    // One control word: the action on the datapath, and a jump taken when the
    // condition holds (otherwise the step counter advances by one).
    typedef struct packed {
        logic  ready;
        t_act  act;
        t_cond cond;
        t_step target;
    } t_uword;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{ready: 1'b0, act: ACT_NONE, cond: C_ALWAYS, target: STEP_FETCH};
        unique case (step)
            STEP_FETCH:     w = '{1'b1, ACT_LOAD,      C_NO_ACCEPT,    STEP_FETCH};
            STEP_CHK_IDLE:  w = '{1'b0, ACT_NONE,      C_IDLE,         STEP_FETCH};
            STEP_CHK_TERM:  w = '{1'b0, ACT_NONE,      C_TERM,         STEP_SCALE_CHK};
            STEP_SAW:       w = '{1'b0, ACT_SAW,       C_NEVER,        STEP_FETCH};
            STEP_CHK_CONS:  w = '{1'b0, ACT_NONE,      C_CONSUME,      STEP_MUL10};
            STEP_CLASSIFY:  w = '{1'b0, ACT_CLASSIFY,  C_ALWAYS,       STEP_FETCH};
            STEP_MUL10:     w = '{1'b0, ACT_MUL10,     C_NEVER,        STEP_FETCH};
            STEP_ADD_DIGIT: w = '{1'b0, ACT_ADD_DIGIT, C_ALWAYS,       STEP_FETCH};
            STEP_SCALE_CHK: w = '{1'b0, ACT_NONE,      C_NO_SCALE_UP,  STEP_ROUND_CHK};
            STEP_SCALE_MUL: w = '{1'b0, ACT_MUL10_EXP, C_ALWAYS,       STEP_SCALE_CHK};
            STEP_ROUND_CHK: w = '{1'b0, ACT_NONE,      C_NO_ROUND,     STEP_OUT_WAIT};
            STEP_ROUND_ADD: w = '{1'b0, ACT_ADD_ONE,   C_NOT_ALL_ONES, STEP_OUT_WAIT};
            STEP_CARRY_FIX: w = '{1'b0, ACT_CARRY_FIX, C_NEVER,        STEP_FETCH};
            STEP_OUT_WAIT:  w = '{1'b0, ACT_NONE,      C_OUT_BUSY,     STEP_OUT_WAIT};
            STEP_EMIT:      w = '{1'b0, ACT_EMIT,      C_ALWAYS,       STEP_FETCH};
            default:        w = '{1'b0, ACT_NONE,      C_ALWAYS,       STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

// File: sv/dsd96_if.sv
// Handshake channels of the digit string to decimal converter: the digit
// item channel and the result channel. Depends on dsd96_pkg.
`timescale 1ns / 1ps

interface dsd96_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      first;
    logic signed [dsd96_pkg::EXP_W-1:0]        decimal_exponent;
    logic                                      negative;
    logic                                      digit_present;
    logic        [dsd96_pkg::DIGIT_W-1:0]      digit;

    modport source (
        output valid, first, decimal_exponent, negative, digit_present, digit,
        input  ready
    );
    modport sink (
        input  valid, first, decimal_exponent, negative, digit_present, digit,
        output ready
    );
endinterface

interface dsd96_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 ok;
    logic [dsd96_pkg::LOW_W-1:0]          mantissa_low;
    logic [dsd96_pkg::HIGH_W-1:0]         mantissa_high;
    logic [dsd96_pkg::SCALE_W-1:0]        scale;
    logic                                 result_negative;

    modport source (
        output valid, ok, mantissa_low, mantissa_high, scale, result_negative,
        input  ready
    );
    modport sink (
        input  valid, ok, mantissa_low, mantissa_high, scale, result_negative,
        output ready
    );
endinterface

// File: sv/digit_string_to_decimal96_core.sv
// Digit string to 96-bit scaled decimal converter, microcoded sequencer.
// Depends on dsd96_pkg, dsd96_if and digit_string_to_decimal96_core_assert.svh.
//
//  Channel   Direction  Moves                                      Transfer when
//  i_item    in         first, exponent, sign, digit or terminator valid & ready
//  o_result  out        ok, 96-bit mantissa, scale, sign           valid & ready
//
// When a digit is accumulated, the multiply by ten and the digit add are
// separate steps on the one 96-bit adder.
// A terminator runs a scale check and a multiply step for every trailing
// multiply by ten (at most 29 of them), then a rounding add when it rounds up
// and a carry fix when the rounding carries out of 96 bits.
// After reset the block is at the fetch step, as for a positive number with
// exponent zero. The result is held in an output register; the step before emit waits
// only while that register still holds a result that has not been taken.
`timescale 1ns / 1ps

`include "digit_string_to_decimal96_core_assert.svh"

module digit_string_to_decimal96_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dsd96_in_if.sink     i_item,
    dsd96_out_if.source  o_result
);

    // Sequencer.
    dsd96_pkg::t_step  r_step, n_step;
    dsd96_pkg::t_uword uw;
    logic              cond_true;

    // Number state.
    logic        [dsd96_pkg::MANT_W-1:0]  r_mant, n_mant;
    logic signed [dsd96_pkg::EXP_W-1:0]   r_exp, n_exp;
    dsd96_pkg::t_phase                    r_phase, n_phase;
    logic                                 r_prev_even, n_prev_even;
    logic        [dsd96_pkg::ZRUN_W-1:0]  r_zero_run, n_zero_run;
    logic                                 r_round_up, n_round_up;
    logic                                 r_sign, n_sign;
    logic                                 r_saw, n_saw;
    logic        [dsd96_pkg::DIGIT_W-1:0] r_digit, n_digit;
    logic                                 r_present, n_present;

    // Output register.
    logic                                 r_out_valid;
    logic                                 r_out_ok;
    logic        [dsd96_pkg::MANT_W-1:0]  r_out_mant;
    logic        [dsd96_pkg::SCALE_W-1:0] r_out_scale;
    logic                                 r_out_neg;

    // Datapath flags.
    logic                                 accept;
    logic                                 mant_below;
    logic                                 mant_at;
    logic                                 below_le;
    logic                                 below_digit;
    logic                                 consume;
    logic                                 scale_up;
    logic                                 do_round;
    logic                                 all_ones;
    logic                                 out_busy;
    logic        [dsd96_pkg::ZRUN_W-1:0]  zero_run_dec;

    // Shared adder.
    logic        [dsd96_pkg::MANT_W-1:0]  add_a;
    logic        [dsd96_pkg::MANT_W-1:0]  add_b;
    logic        [dsd96_pkg::MANT_W-1:0]  add_sum;

    // Result formation.
    logic signed [dsd96_pkg::EXP_W-1:0]   exp_final;
    logic signed [dsd96_pkg::EXP_W-1:0]   exp_neg;
    logic                                 emit_ok;
    logic                                 emit_tiny;

    always_comb begin
        uw = dsd96_pkg::ucode(r_step);
    end

    assign accept       = i_item.valid && uw.ready;
    assign mant_below   = r_mant < dsd96_pkg::MANT_LIMIT;
    assign mant_at      = r_mant == dsd96_pkg::MANT_LIMIT;
    assign below_le     = mant_below || mant_at;
    assign below_digit  = mant_below || (mant_at && (r_digit <= dsd96_pkg::DIGIT_HALF));
    assign consume      = (r_phase == dsd96_pkg::PH_ACC) && (r_exp > dsd96_pkg::EXP_MIN_ACC)
                          && below_digit;
    assign scale_up     = (r_phase == dsd96_pkg::PH_ACC) && r_saw && (r_exp > 16'sd0)
                          && below_le;
    assign do_round     = r_round_up && r_saw && (r_phase != dsd96_pkg::PH_FAIL);
    assign all_ones     = &r_mant;
    assign out_busy     = r_out_valid && !o_result.ready;
    assign zero_run_dec = r_zero_run - 5'd1;

    // An empty number with a positive exponent is taken as exponent zero.
    assign exp_final = (!r_saw && (r_exp > 16'sd0)) ? 16'sd0 : r_exp;
    assign exp_neg   = 16'sd0 - exp_final;
    assign emit_ok   = (r_phase != dsd96_pkg::PH_FAIL) && (exp_final <= 16'sd0);
    assign emit_tiny = exp_final <= dsd96_pkg::EXP_TINY;

    // The multiply by ten is (m << 3) + (m << 1) on the same adder as the
    // digit and rounding increments.
    always_comb begin
        add_a = r_mant;
        add_b = '0;
        case (uw.act) inside
            dsd96_pkg::ACT_MUL10, dsd96_pkg::ACT_MUL10_EXP: begin
                add_a = r_mant << 3;
                add_b = r_mant << 1;
            end
            dsd96_pkg::ACT_ADD_DIGIT: begin
                add_b = {{(dsd96_pkg::MANT_W - dsd96_pkg::DIGIT_W){1'b0}}, r_digit};
            end
            dsd96_pkg::ACT_ADD_ONE: begin
                add_b = {{(dsd96_pkg::MANT_W - 1){1'b0}}, 1'b1};
            end
            default: begin
                add_b = '0;
            end
        endcase
        add_sum = add_a + add_b;
    end

    // Condition select and next step.
    always_comb begin
        unique case (uw.cond)
            dsd96_pkg::C_NEVER:        cond_true = 1'b0;
            dsd96_pkg::C_ALWAYS:       cond_true = 1'b1;
            dsd96_pkg::C_NO_ACCEPT:    cond_true = !accept;
            dsd96_pkg::C_IDLE:         cond_true = r_phase == dsd96_pkg::PH_IDLE;
            dsd96_pkg::C_TERM:         cond_true = !r_present;
            dsd96_pkg::C_CONSUME:      cond_true = consume;
            dsd96_pkg::C_NO_SCALE_UP:  cond_true = !scale_up;
            dsd96_pkg::C_NO_ROUND:     cond_true = !do_round;
            dsd96_pkg::C_NOT_ALL_ONES: cond_true = !all_ones;
            dsd96_pkg::C_OUT_BUSY:     cond_true = out_busy;
            default:                   cond_true = 1'b1;
        endcase
        n_step = cond_true ? uw.target : r_step + 4'd1;
    end

    // Datapath actions.
    always_comb begin
        n_mant      = r_mant;
        n_exp       = r_exp;
        n_phase     = r_phase;
        n_prev_even = r_prev_even;
        n_zero_run  = r_zero_run;
        n_round_up  = r_round_up;
        n_sign      = r_sign;
        n_saw       = r_saw;
        n_digit     = r_digit;
        n_present   = r_present;
        unique case (uw.act)
            dsd96_pkg::ACT_LOAD: begin
                if (accept) begin
                    n_digit   = i_item.digit;
                    n_present = i_item.digit_present;
                    if (i_item.first) begin
                        n_mant      = '0;
                        n_exp       = i_item.decimal_exponent;
                        n_phase     = dsd96_pkg::PH_ACC;
                        n_prev_even = 1'b1;
                        n_zero_run  = dsd96_pkg::LOOKAHEAD_ZEROS;
                        n_round_up  = 1'b0;
                        n_sign      = i_item.negative;
                        n_saw       = 1'b0;
                    end
                end
            end
            dsd96_pkg::ACT_SAW: begin
                if (!r_saw) begin
                    n_saw = 1'b1;
                    if ((r_phase == dsd96_pkg::PH_ACC) && (r_exp > dsd96_pkg::EXP_MAX)) begin
                        n_phase = dsd96_pkg::PH_FAIL;
                    end
                end
            end
            dsd96_pkg::ACT_CLASSIFY: begin
                // First digit that is not consumed decides the rounding; a five
                // after an even digit looks ahead over the following zeros.
                if (r_phase == dsd96_pkg::PH_ACC) begin
                    if (r_digit > dsd96_pkg::DIGIT_HALF) begin
                        n_round_up = 1'b1;
                        n_phase    = dsd96_pkg::PH_SINK;
                    end else if (r_digit == dsd96_pkg::DIGIT_HALF) begin
                        if (!r_prev_even) begin
                            n_round_up = 1'b1;
                            n_phase    = dsd96_pkg::PH_SINK;
                        end else begin
                            n_zero_run = dsd96_pkg::LOOKAHEAD_ZEROS;
                            n_phase    = dsd96_pkg::PH_LOOK;
                        end
                    end else begin
                        n_phase = dsd96_pkg::PH_SINK;
                    end
                end else if (r_phase == dsd96_pkg::PH_LOOK) begin
                    if (r_digit != '0) begin
                        n_round_up = 1'b1;
                        n_phase    = dsd96_pkg::PH_SINK;
                    end else begin
                        n_zero_run = zero_run_dec;
                        if (zero_run_dec == '0) begin
                            n_phase = dsd96_pkg::PH_SINK;
                        end
                    end
                end
            end
            dsd96_pkg::ACT_MUL10: begin
                n_mant = add_sum;
            end
            dsd96_pkg::ACT_ADD_DIGIT: begin
                n_mant      = add_sum;
                n_exp       = r_exp - 16'sd1;
                n_prev_even = !r_digit[0];
            end
            dsd96_pkg::ACT_MUL10_EXP: begin
                n_mant = add_sum;
                n_exp  = r_exp - 16'sd1;
            end
            dsd96_pkg::ACT_ADD_ONE: begin
                n_mant = add_sum;
            end
            dsd96_pkg::ACT_CARRY_FIX: begin
                n_mant = dsd96_pkg::MANT_CARRY_FIX;
                n_exp  = r_exp + 16'sd1;
            end
            dsd96_pkg::ACT_EMIT: begin
                n_exp   = exp_final;
                n_phase = dsd96_pkg::PH_IDLE;
            end
            default: begin
                n_mant = r_mant;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= dsd96_pkg::STEP_FETCH;
            r_mant      <= '0;
            r_exp       <= '0;
            r_phase     <= dsd96_pkg::PH_ACC;
            r_prev_even <= 1'b1;
            r_zero_run  <= dsd96_pkg::LOOKAHEAD_ZEROS;
            r_round_up  <= 1'b0;
            r_sign      <= 1'b0;
            r_saw       <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_mant      <= n_mant;
            r_exp       <= n_exp;
            r_phase     <= n_phase;
            r_prev_even <= n_prev_even;
            r_zero_run  <= n_zero_run;
            r_round_up  <= n_round_up;
            r_sign      <= n_sign;
            r_saw       <= n_saw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit   <= n_digit;
        r_present <= n_present;
    end

    // Output register: loaded at the emit step, cleared once the transfer is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.act == dsd96_pkg::ACT_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.act == dsd96_pkg::ACT_EMIT) begin
            if (!emit_ok) begin
                r_out_ok    <= 1'b0;
                r_out_mant  <= '0;
                r_out_scale <= '0;
                r_out_neg   <= 1'b0;
            end else if (emit_tiny) begin
                r_out_ok    <= 1'b1;
                r_out_mant  <= '0;
                r_out_scale <= dsd96_pkg::SCALE_TINY;
                r_out_neg   <= r_sign;
            end else begin
                r_out_ok    <= 1'b1;
                r_out_mant  <= r_mant;
                r_out_scale <= exp_neg[dsd96_pkg::SCALE_W-1:0];
                r_out_neg   <= r_sign;
            end
        end
    end

    assign i_item.ready             = uw.ready;
    assign o_result.valid           = r_out_valid;
    assign o_result.ok              = r_out_ok;
    assign o_result.mantissa_low    = r_out_mant[dsd96_pkg::LOW_W-1:0];
    assign o_result.mantissa_high   = r_out_mant[dsd96_pkg::MANT_W-1:dsd96_pkg::LOW_W];
    assign o_result.scale           = r_out_scale;
    assign o_result.result_negative = r_out_neg;

    // A new result never replaces one that is still waiting.
    `ASSERT_IMPLIES(a_emit_no_overwrite, i_clk, i_rst_n,
                    uw.act == dsd96_pkg::ACT_EMIT, !out_busy)
    // Multiplies by ten only run on a mantissa that cannot leave 96 bits.
    `ASSERT_IMPLIES(a_mul_in_range, i_clk, i_rst_n,
                    (r_step == dsd96_pkg::STEP_MUL10) || (r_step == dsd96_pkg::STEP_SCALE_MUL),
                    below_le)
    // Trailing multiplies only happen while the exponent is still positive.
    `ASSERT_IMPLIES(a_scale_exp_pos, i_clk, i_rst_n,
                    r_step == dsd96_pkg::STEP_SCALE_MUL, r_exp > 16'sd0)
    // Once a result is emitted the number is closed.
    `ASSERT_NEXT(a_idle_after_emit, i_clk, i_rst_n, uw.act == dsd96_pkg::ACT_EMIT,
                 (r_phase == dsd96_pkg::PH_IDLE) && r_out_valid)
    // A delivered scale never exceeds 28.
    `ASSERT_IMPLIES(a_scale_range, i_clk, i_rst_n,
                    r_out_valid, r_out_scale <= dsd96_pkg::SCALE_TINY)

endmodule
